@@ hw/rtl/rc6_pkg.sv @@
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared types, constants and helpers of the RC6 forty-round block cipher.
// ----------------------------------------------------------------------------
`default_nettype none
package rc6_pkg;
  localparam int Rounds = 40;
  localparam int NKeys = 2 * Rounds + 4;
  localparam int KeyIdxW = $clog2(NKeys);
  localparam int RoundW = $clog2(Rounds + 1);
  localparam int SchedSteps = 3 * NKeys;
  localparam int SchedW = $clog2(SchedSteps + 1);
  localparam logic [31:0] KeyP = 32'hb7e15163;
  localparam logic [31:0] KeyQ = 32'h9e3779b9;

  localparam logic [7:0] MixTable [32] = '{
    8'h76, 8'hb7, 8'h4b, 8'h98, 8'h4c, 8'h5b, 8'hd5, 8'he3,
    8'hc1, 8'h92, 8'h33, 8'h6a, 8'h7b, 8'he6, 8'hcc, 8'heb,
    8'h17, 8'h9a, 8'h77, 8'hbc, 8'h31, 8'h5d, 8'he7, 8'h39,
    8'ha9, 8'h32, 8'h54, 8'h88, 8'h66, 8'hd3, 8'hce, 8'h43
  };

  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] in_a;
    logic [31:0] in_b;
    logic [31:0] in_c;
    logic [31:0] in_d;
  } rc6_in_t;

  typedef struct packed {
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic [31:0] out_c;
    logic [31:0] out_d;
  } rc6_out_t;

  typedef enum logic [2:0] {
    ST_INIT, ST_FILL, ST_MIX, ST_IDLE, ST_PRE, ST_ROUND, ST_POST, ST_OUT
  } rc6_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  // key word j: table bytes plus sign-extended key bytes, high key byte first
  function automatic logic [31:0] key_word(input logic [2:0] j, input logic [31:0] k);
    logic [31:0] w;
    logic [31:0] v;
    w = '0;
    for (int n = 0; n < 4; n++) begin
      v = {24'd0, MixTable[{j, 2'(n)}]} + {{24{k[8*(3-n)+7]}}, k[8*(3-n) +: 8]};
      w = w + (v << (8 * n));
    end
    return w;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/rc6_round_unit.sv @@
// ----------------------------------------------------------------------------
// rc6_round_unit
// Shared round datapath: one encryption or decryption round per call.
// ----------------------------------------------------------------------------
`default_nettype none
module rc6_round_unit
  import rc6_pkg::*;
(
  input  wire logic        decrypt,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] c_i,
  input  wire logic [31:0] d_i,
  input  wire logic [31:0] ka,
  input  wire logic [31:0] kc,
  output logic [31:0]      a_o,
  output logic [31:0]      b_o,
  output logic [31:0]      c_o,
  output logic [31:0]      d_o
);
  logic [31:0] bb, dd, pb, pd, t, u, na, nc;

  always_comb begin
    // decrypt rotates words right first
    bb = decrypt ? a_i : b_i;
    dd = decrypt ? c_i : d_i;
    pb = bb * {bb[30:0], 1'b1};
    pd = dd * {dd[30:0], 1'b1};
    t  = rotl32(pb, 5'd5);
    u  = rotl32(pd, 5'd5);
    if (!decrypt) begin
      na  = rotl32(a_i ^ t, u[4:0]) + ka;
      nc  = rotl32(c_i ^ u, t[4:0]) + kc;
      a_o = b_i;
      b_o = nc;
      c_o = d_i;
      d_o = na;
    end else begin
      na  = rotr32(d_i - ka, u[4:0]) ^ t;
      nc  = rotr32(b_i - kc, t[4:0]) ^ u;
      a_o = na;
      b_o = a_i;
      c_o = nc;
      d_o = c_i;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rc6_forty_round_block_cipher.sv @@
// ----------------------------------------------------------------------------
// rc6_forty_round_block_cipher
// RC6 variant, 40 rounds, 32-bit session key, key expansion on key write.
// ----------------------------------------------------------------------------
// After an input transfer the block passes pre, 40 rounds and post before the result is valid.
// One shared round unit, one round a cycle; a new input is taken only once the result is taken.
// Key expansion (INIT, FILL, MIX) runs after reset and after each key write;
// no input transfer is taken meanwhile. Reset expands key zero.
`default_nettype none
module rc6_forty_round_block_cipher
  import rc6_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rc6_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rc6_out_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [1:0] AddrKey = 2'd0;

  rc6_state_t state_r, state_nxt;
  logic [31:0] key_r;
  logic [31:0] rk_r [NKeys];
  logic [31:0] ls_r [8];
  logic [SchedW-1:0] cnt_r;
  logic [KeyIdxW-1:0] ki_r;
  logic [2:0] lj_r;
  logic [31:0] sa_r, sb_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic dec_r;
  logic [RoundW-1:0] rnd_r;
  logic key_wr;
  logic [31:0] ra, rb, rc, rd, sa_n, sb_n, s_sum;
  logic [KeyIdxW-1:0] rd_a, rd_c;
  logic [31:0] rka_r, rkc_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == AddrKey) ? key_r : '0;
  assign key_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == AddrKey;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  if (cnt_r == SchedW'(7)) state_nxt = ST_FILL;
      ST_FILL:  if (cnt_r == SchedW'(NKeys - 1)) state_nxt = ST_MIX;
      ST_MIX:   if (cnt_r == SchedW'(SchedSteps - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_PRE;
      ST_PRE:   state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == RoundW'(Rounds - 1)) state_nxt = ST_POST;
      ST_POST:  state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_INIT;
    endcase
    if (key_wr) state_nxt = ST_INIT;
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    out_data  = '{out_a: a_r, out_b: b_r, out_c: c_r, out_d: d_r};
  end

  // key schedule mixing step
  always_comb begin
    s_sum = sa_r + sb_r;
    sa_n  = rotl32(rka_r + s_sum, 5'd3);
    sb_n  = rotl32(ls_r[lj_r] + sa_n + sb_r, 5'(sa_n + sb_r));
  end

  // round key pair address for the next cycle (next schedule index while mixing): encrypt counts up, decrypt down
  always_comb begin
    rd_a = '0;
    case (state_r)
      ST_MIX: begin
        rd_a = (ki_r == KeyIdxW'(NKeys - 1)) ? '0 : ki_r + KeyIdxW'(1);
      end
      ST_IDLE: begin
        rd_a = (in_data.action == ActDecrypt) ? KeyIdxW'(NKeys - 2) : '0;
      end
      ST_PRE: begin
        rd_a = dec_r ? KeyIdxW'(2 * Rounds) : KeyIdxW'(2);
      end
      ST_ROUND: begin
        if (rnd_r == RoundW'(Rounds - 1)) rd_a = dec_r ? '0 : KeyIdxW'(NKeys - 2);
        else if (dec_r) rd_a = KeyIdxW'(2 * (Rounds - 1 - 32'(rnd_r)));
        else rd_a = KeyIdxW'(2 * (32'(rnd_r) + 2));
      end
      default: begin
        rd_a = '0;
      end
    endcase
    rd_c = {rd_a[KeyIdxW-1:1], 1'b1};
  end

  rc6_round_unit u_round (
    .decrypt(dec_r), .a_i(a_r), .b_i(b_r), .c_i(c_r), .d_i(d_r),
    .ka(rka_r), .kc(rkc_r),
    .a_o(ra), .b_o(rb), .c_o(rc), .d_o(rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      key_r   <= '0;
      cnt_r   <= '0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (key_wr) key_r <= cfg_pwdata;
      if (key_wr || state_nxt != state_r) cnt_r <= '0;
      else cnt_r <= cnt_r + SchedW'(1);
      if (state_r == ST_ROUND) rnd_r <= rnd_r + RoundW'(1);
      else rnd_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    rka_r <= rk_r[rd_a];
    rkc_r <= rk_r[rd_c];
    case (state_r)
      ST_INIT: begin
        ls_r[cnt_r[2:0]] <= key_word(cnt_r[2:0], key_r);
        ki_r <= '0;
        lj_r <= '0;
        sa_r <= '0;
        sb_r <= '0;
      end
      ST_FILL: begin
        rk_r[cnt_r[KeyIdxW-1:0]] <= KeyP + KeyQ * 32'(cnt_r);
      end
      ST_MIX: begin
        rk_r[ki_r] <= sa_n;
        ls_r[lj_r] <= sb_n;
        sa_r <= sa_n;
        sb_r <= sb_n;
        ki_r <= (ki_r == KeyIdxW'(NKeys - 1)) ? '0 : ki_r + KeyIdxW'(1);
        lj_r <= lj_r + 3'd1;
      end
      ST_IDLE: begin
        dec_r <= in_data.action;
        a_r <= in_data.in_a;
        b_r <= in_data.in_b;
        c_r <= in_data.in_c;
        d_r <= in_data.in_d;
      end
      ST_PRE: begin
        if (dec_r == ActEncrypt) begin
          b_r <= b_r + rka_r;
          d_r <= d_r + rkc_r;
        end else begin
          a_r <= (a_r ^ key_r) - rka_r;
          b_r <= b_r ^ key_r;
          c_r <= (c_r ^ key_r) - rkc_r;
          d_r <= d_r ^ key_r;
        end
      end
      ST_ROUND: begin
        a_r <= ra;
        b_r <= rb;
        c_r <= rc;
        d_r <= rd;
      end
      ST_POST: begin
        if (dec_r == ActEncrypt) begin
          a_r <= (a_r + rka_r) ^ key_r;
          b_r <= b_r ^ key_r;
          c_r <= (c_r + rkc_r) ^ key_r;
          d_r <= d_r ^ key_r;
        end else begin
          b_r <= b_r - rka_r;
          d_r <= d_r - rkc_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !key_wr |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> state_r == ST_INIT) else $error("key write did not restart expansion");
endmodule
`default_nettype wire

@@ verif/rc6_forty_round_block_cipher_tb.sv @@
// ----------------------------------------------------------------------------
// rc6_forty_round_block_cipher_tb
// Drives encrypt and decrypt blocks under several session keys with random
// gaps and stalls on both channels. A local cipher model predicts each block
// and the monitor compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rc6_forty_round_block_cipher_tb;
  import rc6_pkg::*;

  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rc6_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rc6_out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  rc6_forty_round_block_cipher dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [31:0] sess_key;
  logic [31:0] sched [NKeys];
  rc6_in_t pending_blocks [$];
  rc6_out_t expected_blocks [$];
  int err_count = 0;
  int cycle_count = 0;
  int out_hold = 0;
  int long_hold = 0;
  int in_gap = 0;
  int sent_count = 0;
  int recv_count = 0;

  function automatic logic [31:0] rol(logic [31:0] x, logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    return (s == 0) ? x : ((x << s) | (x >> (6'd32 - s)));
  endfunction

  function automatic logic [31:0] ror(logic [31:0] x, logic [31:0] n);
    return rol(x, 32'd32 - {27'd0, n[4:0]});
  endfunction

  function automatic void expand_schedule(logic [31:0] k);
    logic [31:0] lw [8];
    logic [31:0] a, b, w, kb;
    int i, j;
    for (j = 0; j < 8; j++) begin
      w = 0;
      for (int n = 0; n < 4; n++) begin
        kb = {{24{k[8*(3-n)+7]}}, k[8*(3-n) +: 8]};
        w = w + (({24'd0, MixTable[4*j+n]} + kb) << (8 * n));
      end
      lw[j] = w;
    end
    sched[0] = KeyP;
    for (i = 1; i < NKeys; i++) sched[i] = sched[i-1] + KeyQ;
    a = 0; b = 0; i = 0; j = 0;
    for (int s = 0; s < 3 * NKeys; s++) begin
      sched[i] = rol(sched[i] + a + b, 3);
      a = sched[i];
      lw[j] = rol(lw[j] + a + b, a + b);
      b = lw[j];
      i = (i + 1) % NKeys;
      j = (j + 1) % 8;
    end
    sess_key = k;
  endfunction

  function automatic rc6_out_t cipher_block(rc6_in_t it);
    logic [31:0] a, b, c, d, t, u, x;
    rc6_out_t r;
    a = it.in_a; b = it.in_b; c = it.in_c; d = it.in_d;
    if (it.action == ActEncrypt) begin
      b += sched[0];
      d += sched[1];
      for (int i = 2; i <= 2 * Rounds; i += 2) begin
        t = rol(b * (2 * b + 1), 5);
        u = rol(d * (2 * d + 1), 5);
        a = rol(a ^ t, u) + sched[i];
        c = rol(c ^ u, t) + sched[i+1];
        x = a; a = b; b = c; c = d; d = x;
      end
      a = (a + sched[2*Rounds+2]) ^ sess_key;
      b ^= sess_key;
      c = (c + sched[2*Rounds+3]) ^ sess_key;
      d ^= sess_key;
    end else begin
      a = (a ^ sess_key) - sched[2*Rounds+2];
      b ^= sess_key;
      c = (c ^ sess_key) - sched[2*Rounds+3];
      d ^= sess_key;
      for (int i = 2 * Rounds; i >= 2; i -= 2) begin
        x = d; d = c; c = b; b = a; a = x;
        u = rol(d * (2 * d + 1), 5);
        t = rol(b * (2 * b + 1), 5);
        c = ror(c - sched[i+1], t) ^ u;
        a = ror(a - sched[i], u) ^ t;
      end
      b -= sched[0];
      d -= sched[1];
    end
    r.out_a = a; r.out_b = b; r.out_c = c; r.out_d = d;
    return r;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_blocks.push_back(cipher_block(in_data));
    end
    if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        in_data <= pending_blocks.pop_front();
        sent_count++;
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rc6_out_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (out_valid && out_ready) begin
      recv_count++;
      if (expected_blocks.size() == 0) begin
        $error("unexpected result transfer");
        err_count++;
      end else begin
        exp_r = expected_blocks.pop_front();
        if (out_data.out_a !== exp_r.out_a) begin
          $error("out_a exp %h got %h", exp_r.out_a, out_data.out_a);
          err_count++;
        end
        if (out_data.out_b !== exp_r.out_b) begin
          $error("out_b exp %h got %h", exp_r.out_b, out_data.out_b);
          err_count++;
        end
        if (out_data.out_c !== exp_r.out_c) begin
          $error("out_c exp %h got %h", exp_r.out_c, out_data.out_c);
          err_count++;
        end
        if (out_data.out_d !== exp_r.out_d) begin
          $error("out_d exp %h got %h", exp_r.out_d, out_data.out_d);
          err_count++;
        end
      end
    end
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_hold <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  task automatic write_key(logic [31:0] k);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= k;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    expand_schedule(k);
  endtask

  task automatic drain_all();
    while (pending_blocks.size() > 0 || recv_count != sent_count)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic rc6_in_t rand_block();
    rc6_in_t it;
    it.action = 1'($urandom_range(0, 1));
    it.in_a = $urandom; it.in_b = $urandom; it.in_c = $urandom; it.in_d = $urandom;
    return it;
  endfunction

  initial begin
    logic [31:0] keys [6];
    rc6_in_t it;
    keys = '{32'h0, 32'hffffffff, 32'h80808080, 32'h7f7f7f7f, 32'h0, 32'h0};
    keys[4] = $urandom;
    keys[5] = $urandom;
    expand_schedule(32'h0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // directed blocks under the reset key
    for (int act = 0; act < 2; act++) begin
      it.action = act[0];
      it.in_a = 0; it.in_b = 0; it.in_c = 0; it.in_d = 0;
      pending_blocks.push_back(it);
      it.in_a = '1; it.in_b = '1; it.in_c = '1; it.in_d = '1;
      pending_blocks.push_back(it);
      it.in_a = 32'h80000000; it.in_b = 32'h1; it.in_c = 32'h7fffffff; it.in_d = 32'hfffffffe;
      pending_blocks.push_back(it);
      it.in_a = 32'h01234567; it.in_b = 32'h89abcdef; it.in_c = 32'hfedcba98;
      it.in_d = 32'h76543210;
      pending_blocks.push_back(it);
    end
    drain_all();
    for (int p = 0; p < 6; p++) begin
      write_key(keys[p]);
      if (p == 2) long_hold <= 1500;
      for (int n = 0; n < 75; n++) pending_blocks.push_back(rand_block());
      drain_all();
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
